// File: design/qnm_pkg.sv
// Shared types, constants and helper functions for the quaternion normalize / matrix unit.
// Holds the reciprocal square root seed ROM, built at elaboration.
// No dependencies.
package qnm_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC     = 14;
    localparam int TBL_BITS = 8;
    localparam int Q_BITS   = 30;
    localparam int IDX_W    = 4;
    localparam int N_ELEM   = 9;
    localparam int N_COMP   = 4;
    localparam int N_PROD   = 10;
    localparam int N_STAGE  = 9;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ENT_W    = PROD_W + 2;
    localparam int MQ_W     = 32;
    localparam int SH_W     = 6;
    localparam int Y0_W     = 31;
    localparam int Y1_W     = 32;
    localparam int CMAG_W   = DATA_W + 1;
    localparam int CPROD_W  = 49;
    localparam int MAG_W    = 50;
    localparam int N_RSQ    = 6;

    localparam logic MODE_NORM = 1'b0;
    localparam logic MODE_MAT  = 1'b1;

    localparam logic [IDX_W-1:0] LAST_NORM = IDX_W'(N_COMP - 1);
    localparam logic [IDX_W-1:0] LAST_MAT  = IDX_W'(N_ELEM - 1);

    localparam longint LIM = 64'd1 << (DATA_W - 1);
    localparam logic signed [ENT_W-1:0] MAT_ONE = ENT_W'(64'd1 << (2 * FRAC - 1));

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic                               mode;
        logic                               zero;
        logic [N_ELEM-1:0][DATA_W-1:0]      vals;
        logic [N_ELEM-1:0]                  errs;
    } t_side;

    typedef struct packed {
        t_side                              side;
        logic [SH_W-1:0]                    sh;
        logic [N_COMP-1:0][CPROD_W-1:0]     prod;
    } t_merge_in;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              err;
    } t_res;

    typedef logic [2**TBL_BITS-1:0][Y0_W-1:0] t_seed_rom;

    function automatic t_res clamp_out(input logic neg, input logic [MAG_W-1:0] mag);
        t_res r;
        r.err = 1'b0;
        if (neg) begin
            if (mag > MAG_W'(LIM)) begin
                r.err = 1'b1;
                r.val = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r.val = DATA_W'(MAG_W'(0) - mag);
            end
        end else begin
            if (mag > MAG_W'(LIM - 1)) begin
                r.err = 1'b1;
                r.val = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                r.val = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_seed_rom build_seed_rom();
        t_seed_rom   rom;
        logic [63:0] mid;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        logic [63:0] q;
        logic [63:0] cand;
        for (int i = 0; i < 2**TBL_BITS; i++) begin
            mid = (64'd1 << Q_BITS) + (64'(2 * i + 1) << (Q_BITS + 1 - TBL_BITS));
            v   = mid << Q_BITS;
            r   = 64'd0;
            bt  = 64'd1 << 62;
            for (int j = 0; j < 32; j++) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            q = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                cand = q | (64'd1 << b);
                if (cand * r <= (64'd1 << 60)) begin
                    q = cand;
                end
            end
            rom[i] = q[Y0_W-1:0];
        end
        return rom;
    endfunction

    localparam t_seed_rom SEED_ROM = build_seed_rom();

endpackage

// File: design/quaternion_normalize_to_matrix_top.sv
// Top level of the quaternion normalize / rotation matrix unit.
// Uses qnm_pkg, qnm_lane, qnm_rsqrt and qnm_merge.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------------
//  input    | i_valid  | o_stall  | i_mode, i_comp_x, i_comp_y, i_comp_z, i_comp_w
//  result   | o_valid  | i_stall  | o_result_value, o_element_index, o_last_element,
//           |          |          | o_error_flag
//
// Nine pipeline stages plus the merge register.
// Results leave one per cycle from the merge register while i_stall is low: 4 per normalize item,
// 9 per convert item, so the result port sets the sustained item rate.
// Each stage advances when empty or when the next one moves; o_stall follows from that.
// Reset clears stage valid bits and the result counter.
module quaternion_normalize_to_matrix_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic signed [qnm_pkg::DATA_W-1:0]  i_comp_x,
    input  logic signed [qnm_pkg::DATA_W-1:0]  i_comp_y,
    input  logic signed [qnm_pkg::DATA_W-1:0]  i_comp_z,
    input  logic signed [qnm_pkg::DATA_W-1:0]  i_comp_w,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [qnm_pkg::DATA_W-1:0]  o_result_value,
    output logic [qnm_pkg::IDX_W-1:0]          o_element_index,
    output logic                               o_last_element,
    output logic                               o_error_flag
);

    logic [qnm_pkg::N_STAGE:0]                en;
    logic [qnm_pkg::N_STAGE-1:0]              r_vld;

    qnm_pkg::t_data                           op_a [qnm_pkg::N_PROD];
    qnm_pkg::t_data                           op_b [qnm_pkg::N_PROD];
    logic signed [qnm_pkg::PROD_W-1:0]        p1   [qnm_pkg::N_PROD];

    qnm_pkg::t_side                           n_side0;
    qnm_pkg::t_side                           n_side2;
    qnm_pkg::t_side                           r_side [qnm_pkg::N_STAGE];

    logic signed [qnm_pkg::ENT_W-1:0]         ex     [qnm_pkg::N_PROD];
    logic signed [qnm_pkg::ENT_W-1:0]         n_ent  [qnm_pkg::N_ELEM];
    logic signed [qnm_pkg::ENT_W-1:0]         r_ent  [qnm_pkg::N_ELEM];
    logic [qnm_pkg::SUM_W-1:0]                r_sum;

    logic [qnm_pkg::Y1_W-1:0]                 y1;
    logic [qnm_pkg::SH_W-1:0]                 sh7;
    logic [qnm_pkg::SH_W-1:0]                 r_sh8;
    logic signed [qnm_pkg::CMAG_W:0]          cmag [qnm_pkg::N_COMP];
    logic signed [qnm_pkg::CMAG_W+qnm_pkg::Y1_W+1:0] p9 [qnm_pkg::N_COMP];

    qnm_pkg::t_merge_in                       m_in;
    logic                                     merge_ready;

    assign en[qnm_pkg::N_STAGE] = merge_ready;

    for (genvar k = 0; k < qnm_pkg::N_STAGE; k++) begin : g_en
        assign en[k] = ~r_vld[k] | en[k+1];
    end

    assign o_stall = ~en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < qnm_pkg::N_STAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // products: xx yy zz ww xy zx yz wx wy wz
    always_comb begin
        op_a[0] = i_comp_x;  op_b[0] = i_comp_x;
        op_a[1] = i_comp_y;  op_b[1] = i_comp_y;
        op_a[2] = i_comp_z;  op_b[2] = i_comp_z;
        op_a[3] = i_comp_w;  op_b[3] = i_comp_w;
        op_a[4] = i_comp_x;  op_b[4] = i_comp_y;
        op_a[5] = i_comp_z;  op_b[5] = i_comp_x;
        op_a[6] = i_comp_y;  op_b[6] = i_comp_z;
        op_a[7] = i_comp_w;  op_b[7] = i_comp_x;
        op_a[8] = i_comp_w;  op_b[8] = i_comp_y;
        op_a[9] = i_comp_w;  op_b[9] = i_comp_z;
    end

    for (genvar i = 0; i < qnm_pkg::N_PROD; i++) begin : g_sq_lane
        qnm_lane #(
            .A_W (qnm_pkg::DATA_W),
            .B_W (qnm_pkg::DATA_W)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en[0]),
            .i_a   (op_a[i]),
            .i_b   (op_b[i]),
            .o_p   (p1[i])
        );
    end

    always_comb begin
        n_side0      = '0;
        n_side0.mode = i_mode;
        n_side0.vals[0] = i_comp_x;
        n_side0.vals[1] = i_comp_y;
        n_side0.vals[2] = i_comp_z;
        n_side0.vals[3] = i_comp_w;
    end

    always_comb begin
        for (int i = 0; i < qnm_pkg::N_PROD; i++) begin
            ex[i] = qnm_pkg::ENT_W'(p1[i]);
        end
        n_ent[0] = qnm_pkg::MAT_ONE - ex[1] - ex[2];
        n_ent[1] = ex[4] - ex[9];
        n_ent[2] = ex[5] + ex[8];
        n_ent[3] = ex[4] + ex[9];
        n_ent[4] = qnm_pkg::MAT_ONE - ex[0] - ex[2];
        n_ent[5] = ex[6] - ex[7];
        n_ent[6] = ex[5] - ex[8];
        n_ent[7] = ex[6] + ex[7];
        n_ent[8] = qnm_pkg::MAT_ONE - ex[0] - ex[1];
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_sum <= qnm_pkg::SUM_W'(p1[0][qnm_pkg::PROD_W-2:0])
                   + qnm_pkg::SUM_W'(p1[1][qnm_pkg::PROD_W-2:0])
                   + qnm_pkg::SUM_W'(p1[2][qnm_pkg::PROD_W-2:0])
                   + qnm_pkg::SUM_W'(p1[3][qnm_pkg::PROD_W-2:0]);
            for (int k = 0; k < qnm_pkg::N_ELEM; k++) begin
                r_ent[k] <= n_ent[k];
            end
        end
    end

    always_comb begin
        logic                          neg;
        logic [qnm_pkg::ENT_W-1:0]     amag;
        logic [qnm_pkg::ENT_W:0]       rnd;
        qnm_pkg::t_res                 res;
        n_side2      = r_side[1];
        n_side2.zero = (r_sum == '0);
        n_side2.errs = '0;
        for (int k = 0; k < qnm_pkg::N_ELEM; k++) begin
            neg  = r_ent[k][qnm_pkg::ENT_W-1];
            amag = neg ? qnm_pkg::ENT_W'(-r_ent[k]) : qnm_pkg::ENT_W'(r_ent[k]);
            rnd  = ({1'b0, amag} + ((qnm_pkg::ENT_W+1)'(1) << (qnm_pkg::FRAC - 2)))
                   >> (qnm_pkg::FRAC - 1);
            res  = qnm_pkg::clamp_out(neg, qnm_pkg::MAG_W'(rnd));
            if (r_side[1].mode == qnm_pkg::MODE_MAT) begin
                n_side2.vals[k] = res.val;
                n_side2.errs[k] = res.err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= n_side0;
        end
        if (en[1]) begin
            r_side[1] <= r_side[0];
        end
        if (en[2]) begin
            r_side[2] <= n_side2;
        end
        for (int k = 3; k < qnm_pkg::N_STAGE; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    qnm_rsqrt u_rsqrt (
        .i_clk (i_clk),
        .i_en  (en[7:2]),
        .i_sum (r_sum),
        .o_y1  (y1),
        .o_sh  (sh7)
    );

    always_comb begin
        logic signed [qnm_pkg::CMAG_W-1:0] cs;
        for (int i = 0; i < qnm_pkg::N_COMP; i++) begin
            cs      = qnm_pkg::CMAG_W'($signed(r_side[7].vals[i]));
            cmag[i] = {1'b0, (cs[qnm_pkg::CMAG_W-1] ? qnm_pkg::CMAG_W'(-cs)
                                                    : qnm_pkg::CMAG_W'(cs))};
        end
    end

    for (genvar i = 0; i < qnm_pkg::N_COMP; i++) begin : g_comp_lane
        qnm_lane #(
            .A_W (qnm_pkg::CMAG_W + 1),
            .B_W (qnm_pkg::Y1_W + 1)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en[8]),
            .i_a   (cmag[i]),
            .i_b   ($signed({1'b0, y1})),
            .o_p   (p9[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_sh8 <= sh7;
        end
    end

    always_comb begin
        m_in.side = r_side[8];
        m_in.sh   = r_sh8;
        for (int i = 0; i < qnm_pkg::N_COMP; i++) begin
            m_in.prod[i] = p9[i][qnm_pkg::CPROD_W-1:0];
        end
    end

    qnm_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_vld[8]),
        .i_item          (m_in),
        .o_ready         (merge_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_value  (o_result_value),
        .o_element_index (o_element_index),
        .o_last_element  (o_last_element),
        .o_error_flag    (o_error_flag)
    );

endmodule

// File: design/qnm_lane.sv
// One multiplier lane: registered signed product with a stage enable.
// No dependencies.
module qnm_lane #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: design/qnm_rsqrt.sv
// Reciprocal square root pipeline: normalize, seed ROM lookup, one Newton step.
// Six stages, each with its own enable. Uses qnm_pkg.
module qnm_rsqrt (
    input  logic                         i_clk,
    input  logic [qnm_pkg::N_RSQ-1:0]    i_en,
    input  logic [qnm_pkg::SUM_W-1:0]    i_sum,
    output logic [qnm_pkg::Y1_W-1:0]     o_y1,
    output logic [qnm_pkg::SH_W-1:0]     o_sh
);

    localparam logic [qnm_pkg::MQ_W-1:0] ONE_Q  = qnm_pkg::MQ_W'(64'd1 << qnm_pkg::Q_BITS);
    localparam logic [32:0]              THREE_Q = 33'(64'd3 << qnm_pkg::Q_BITS);

    logic [qnm_pkg::SH_W-1:0]          msb;
    logic [qnm_pkg::SH_W-1:0]          sh;
    logic [qnm_pkg::SUM_W+29:0]        wide;
    logic [qnm_pkg::MQ_W-1:0]          mq;
    logic [qnm_pkg::MQ_W-1:0]          off;
    logic [61:0]                       sq_c;
    logic [62:0]                       pe_d;
    logic [62:0]                       py_f;

    logic [qnm_pkg::MQ_W-1:0]          r_mq_a;
    logic [qnm_pkg::SH_W-1:0]          r_sh_a;
    logic [qnm_pkg::TBL_BITS-1:0]      r_idx_a;
    logic [qnm_pkg::Y0_W-1:0]          r_y0_b;
    logic [qnm_pkg::MQ_W-1:0]          r_mq_b;
    logic [qnm_pkg::SH_W-1:0]          r_sh_b;
    logic [qnm_pkg::Y0_W-1:0]          r_y0sq_c;
    logic [qnm_pkg::Y0_W-1:0]          r_y0_c;
    logic [qnm_pkg::MQ_W-1:0]          r_mq_c;
    logic [qnm_pkg::SH_W-1:0]          r_sh_c;
    logic [32:0]                       r_e_d;
    logic [qnm_pkg::Y0_W-1:0]          r_y0_d;
    logic [qnm_pkg::SH_W-1:0]          r_sh_d;
    logic [31:0]                       r_t_e;
    logic [qnm_pkg::Y0_W-1:0]          r_y0_e;
    logic [qnm_pkg::SH_W-1:0]          r_sh_e;
    logic [qnm_pkg::Y1_W-1:0]          r_y1_f;
    logic [qnm_pkg::SH_W-1:0]          r_sh_f;

    always_comb begin
        msb = '0;
        for (int i = 0; i < qnm_pkg::SUM_W; i++) begin
            if (i_sum[i]) begin
                msb = qnm_pkg::SH_W'(i);
            end
        end
        sh   = {msb[qnm_pkg::SH_W-1:1], 1'b0};
        wide = {i_sum, 30'b0};
        mq   = qnm_pkg::MQ_W'(wide >> sh);
        off  = mq - ONE_Q;
    end

    assign sq_c = r_y0_b * r_y0_b;
    assign pe_d = r_mq_c * r_y0sq_c;
    assign py_f = r_y0_e * r_t_e;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mq_a  <= mq;
            r_sh_a  <= sh;
            r_idx_a <= off[qnm_pkg::MQ_W-1 -: qnm_pkg::TBL_BITS];
        end
        if (i_en[1]) begin
            r_y0_b <= qnm_pkg::SEED_ROM[r_idx_a];
            r_mq_b <= r_mq_a;
            r_sh_b <= r_sh_a;
        end
        if (i_en[2]) begin
            r_y0sq_c <= sq_c[60:30];
            r_y0_c   <= r_y0_b;
            r_mq_c   <= r_mq_b;
            r_sh_c   <= r_sh_b;
        end
        if (i_en[3]) begin
            r_e_d  <= pe_d[62:30];
            r_y0_d <= r_y0_c;
            r_sh_d <= r_sh_c;
        end
        if (i_en[4]) begin
            r_t_e  <= (r_e_d > THREE_Q) ? 32'd0 : 32'(THREE_Q - r_e_d);
            r_y0_e <= r_y0_d;
            r_sh_e <= r_sh_d;
        end
        if (i_en[5]) begin
            r_y1_f <= py_f[62:31];
            r_sh_f <= r_sh_e;
        end
    end

    assign o_y1 = r_y1_f;
    assign o_sh = r_sh_f;

endmodule

// File: design/qnm_merge.sv
// Merge stage: rounds and clamps the lane results (normalize) or takes the matrix entries as they are, then sends
// them out one element per cycle while i_stall is low. Uses qnm_pkg.
module qnm_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  qnm_pkg::t_merge_in                 i_item,
    output logic                               o_ready,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [qnm_pkg::DATA_W-1:0]  o_result_value,
    output logic [qnm_pkg::IDX_W-1:0]          o_element_index,
    output logic                               o_last_element,
    output logic                               o_error_flag
);

    logic [qnm_pkg::SH_W-1:0]                          d;
    logic [qnm_pkg::N_ELEM-1:0][qnm_pkg::DATA_W-1:0]   n_vals;
    logic [qnm_pkg::N_ELEM-1:0]                        n_errs;
    logic [qnm_pkg::IDX_W-1:0]                         n_last;
    logic                                              take;
    logic                                              is_last;
    logic                                              load;

    logic                                              r_busy;
    logic [qnm_pkg::IDX_W-1:0]                         r_idx;
    logic [qnm_pkg::IDX_W-1:0]                         r_last;
    logic [qnm_pkg::N_ELEM-1:0][qnm_pkg::DATA_W-1:0]   r_vals;
    logic [qnm_pkg::N_ELEM-1:0]                        r_errs;

    always_comb begin
        logic [qnm_pkg::MAG_W-1:0] rnd;
        qnm_pkg::t_res             res;
        d      = qnm_pkg::SH_W'(qnm_pkg::Q_BITS - qnm_pkg::FRAC) + (i_item.sh >> 1);
        n_vals = '0;
        n_errs = '0;
        for (int i = 0; i < qnm_pkg::N_COMP; i++) begin
            rnd = (qnm_pkg::MAG_W'(i_item.prod[i]) + (qnm_pkg::MAG_W'(1) << (d - 1'b1))) >> d;
            res = qnm_pkg::clamp_out(i_item.side.vals[i][qnm_pkg::DATA_W-1], rnd);
            if (i_item.side.zero) begin
                n_vals[i] = '0;
                n_errs[i] = 1'b1;
            end else begin
                n_vals[i] = res.val;
                n_errs[i] = res.err;
            end
        end
        n_last = qnm_pkg::LAST_NORM;
        if (i_item.side.mode == qnm_pkg::MODE_MAT) begin
            n_vals = i_item.side.vals;
            n_errs = i_item.side.errs;
            n_last = qnm_pkg::LAST_MAT;
        end
    end

    assign take    = r_busy & ~i_stall;
    assign is_last = (r_idx == r_last);
    assign o_ready = ~r_busy | (take & is_last);
    assign load    = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vals <= n_vals;
            r_errs <= n_errs;
            r_last <= n_last;
        end
    end

    assign o_valid         = r_busy;
    assign o_result_value  = r_vals[r_idx];
    assign o_element_index = r_idx;
    assign o_last_element  = is_last;
    assign o_error_flag    = r_errs[r_idx];

endmodule

// File: tb/sv/quaternion_normalize_to_matrix_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quaternion_normalize_to_matrix_top: normalize and rotation matrix
// items, a bit-exact predictor, random idling on both channels. Depends on qnm_pkg.
module quaternion_normalize_to_matrix_top_tb;

    localparam int QF          = 30;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 40;

    typedef struct {
        logic           mode;
        qnm_pkg::t_data x;
        qnm_pkg::t_data y;
        qnm_pkg::t_data z;
        qnm_pkg::t_data w;
    } t_quat;

    typedef struct {
        qnm_pkg::t_data            value;
        logic [qnm_pkg::IDX_W-1:0] index;
        logic                      last;
        logic                      err;
    } t_elem;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_mode = qnm_pkg::MODE_NORM;
    qnm_pkg::t_data            i_comp_x = '0;
    qnm_pkg::t_data            i_comp_y = '0;
    qnm_pkg::t_data            i_comp_z = '0;
    qnm_pkg::t_data            i_comp_w = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    qnm_pkg::t_data            o_result_value;
    logic [qnm_pkg::IDX_W-1:0] o_element_index;
    logic                      o_last_element;
    logic                      o_error_flag;

    t_quat quat_backlog[$];
    t_elem expected_elems[$];
    int    n_accepted = 0;
    int    n_items_total = 1 << 30;
    int    n_fail = 0;
    int    src_gap = 0;
    int    sink_gap = 0;
    int    cycle_count = 0;

    quaternion_normalize_to_matrix_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_comp_x(i_comp_x), .i_comp_y(i_comp_y),
        .i_comp_z(i_comp_z), .i_comp_w(i_comp_w),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_value(o_result_value), .o_element_index(o_element_index),
        .o_last_element(o_last_element), .o_error_flag(o_error_flag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_elem make_elem(input logic neg, input longint unsigned mag,
                                        input int k, input logic is_last);
        t_elem           el;
        longint unsigned lim;
        lim      = 64'd1 << (qnm_pkg::DATA_W - 1);
        el.err   = 1'b0;
        el.index = qnm_pkg::IDX_W'(k);
        el.last  = is_last;
        if (neg) begin
            if (mag > lim) begin
                mag    = lim;
                el.err = 1'b1;
            end
            el.value = qnm_pkg::DATA_W'(64'd0 - mag);
        end else begin
            if (mag > lim - 1) begin
                mag    = lim - 1;
                el.err = 1'b1;
            end
            el.value = qnm_pkg::DATA_W'(mag);
        end
        return el;
    endfunction

    function automatic void predict_elements(input t_quat q);
        longint          cv[qnm_pkg::N_COMP];
        longint unsigned cm[qnm_pkg::N_COMP];
        longint          ent[qnm_pkg::N_ELEM];
        longint          half;
        longint unsigned sumsq, mq, mid, seed, seed_sq, est, y1, mag;
        longint          t;
        int              msb, sh, d;
        t_elem           el;
        cv[0] = q.x;
        cv[1] = q.y;
        cv[2] = q.z;
        cv[3] = q.w;
        for (int i = 0; i < qnm_pkg::N_COMP; i++) cm[i] = (cv[i] < 0) ? 64'(-cv[i]) : 64'(cv[i]);
        if (q.mode == qnm_pkg::MODE_MAT) begin
            half   = 64'd1 << (2 * qnm_pkg::FRAC - 1);
            ent[0] = half - cv[1] * cv[1] - cv[2] * cv[2];
            ent[1] = cv[0] * cv[1] - cv[3] * cv[2];
            ent[2] = cv[2] * cv[0] + cv[3] * cv[1];
            ent[3] = cv[0] * cv[1] + cv[3] * cv[2];
            ent[4] = half - cv[0] * cv[0] - cv[2] * cv[2];
            ent[5] = cv[1] * cv[2] - cv[3] * cv[0];
            ent[6] = cv[2] * cv[0] - cv[3] * cv[1];
            ent[7] = cv[1] * cv[2] + cv[3] * cv[0];
            ent[8] = half - cv[0] * cv[0] - cv[1] * cv[1];
            for (int k = 0; k < qnm_pkg::N_ELEM; k++) begin
                mag = (ent[k] < 0) ? 64'(-ent[k]) : 64'(ent[k]);
                mag = (mag + (64'd1 << (qnm_pkg::FRAC - 2))) >> (qnm_pkg::FRAC - 1);
                expected_elems.push_back(make_elem(ent[k] < 0, mag, k,
                                                   k == qnm_pkg::N_ELEM - 1));
            end
        end else begin
            sumsq = 0;
            for (int i = 0; i < qnm_pkg::N_COMP; i++) sumsq = sumsq + cm[i] * cm[i];
            if (sumsq == 0) begin
                for (int i = 0; i < qnm_pkg::N_COMP; i++) begin
                    el.value = '0;
                    el.index = qnm_pkg::IDX_W'(i);
                    el.last  = (i == qnm_pkg::N_COMP - 1);
                    el.err   = 1'b1;
                    expected_elems.push_back(el);
                end
            end else begin
                msb = 63;
                while (sumsq[msb] == 1'b0) msb--;
                sh      = msb & ~1;
                mq      = (sh <= QF) ? (sumsq << (QF - sh)) : (sumsq >> (sh - QF));
                mid     = (64'd1 << QF)
                        + ((2 * ((mq - (64'd1 << QF)) >> (32 - qnm_pkg::TBL_BITS)) + 1)
                           << (QF + 1 - qnm_pkg::TBL_BITS));
                seed    = (64'd1 << 60) / int_sqrt(mid << QF);
                seed_sq = (seed * seed) >> QF;
                est     = (mq * seed_sq) >> QF;
                t       = longint'(64'd3 << QF) - longint'(est);
                if (t < 0) t = 0;
                y1      = (seed * 64'(t)) >> (QF + 1);
                d       = QF + sh / 2 - qnm_pkg::FRAC;
                for (int i = 0; i < qnm_pkg::N_COMP; i++) begin
                    mag = cm[i] * y1;
                    if (d > 0) mag = (mag + (64'd1 << (d - 1))) >> d;
                    expected_elems.push_back(make_elem(cv[i] < 0, mag, i,
                                                       i == qnm_pkg::N_COMP - 1));
                end
            end
        end
    endfunction

    function automatic logic idling_on();
        return (n_accepted < 70) || (n_accepted >= 110 && n_accepted < n_items_total - 40);
    endfunction

    function automatic qnm_pkg::t_data random_comp();
        qnm_pkg::t_data v;
        case ($urandom_range(0, 3))
            0: v = qnm_pkg::t_data'($urandom_range(0, 65535));
            1: begin
                v = qnm_pkg::t_data'($urandom_range(0, 32767) >> $urandom_range(0, 15));
                if ($urandom_range(0, 1)) v = -v;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: v = -16'sd32768;
                    1: v = 16'sd32767;
                    2: v = 16'sd0;
                    3: v = 16'sd16384;
                    default: v = -16'sd16384;
                endcase
            end
            default: v = qnm_pkg::t_data'($signed($urandom_range(0, 32768)) - 16384);
        endcase
        return v;
    endfunction

    task automatic queue_quat(input logic mode, input qnm_pkg::t_data x,
                              input qnm_pkg::t_data y, input qnm_pkg::t_data z,
                              input qnm_pkg::t_data w);
        t_quat q;
        q.mode = mode;
        q.x    = x;
        q.y    = y;
        q.z    = z;
        q.w    = w;
        quat_backlog.push_back(q);
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_quat q;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                q.mode = i_mode;
                q.x    = i_comp_x;
                q.y    = i_comp_y;
                q.z    = i_comp_z;
                q.w    = i_comp_w;
                predict_elements(q);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (quat_backlog.size() != 0 && idling_on()
                             && $urandom_range(0, 99) < 20) begin
                    src_gap = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else if (quat_backlog.size() != 0) begin
                    q = quat_backlog.pop_front();
                    i_valid  <= 1'b1;
                    i_mode   <= q.mode;
                    i_comp_x <= q.x;
                    i_comp_y <= q.y;
                    i_comp_z <= q.z;
                    i_comp_w <= q.w;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_elem el;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_elems.size() == 0) begin
                    $error("unexpected result: value %0d index %0d",
                           o_result_value, o_element_index);
                    n_fail++;
                end else begin
                    el = expected_elems.pop_front();
                    if (o_result_value !== el.value) begin
                        $error("result_value: expected %0d, got %0d", el.value, o_result_value);
                        n_fail++;
                    end
                    if (o_element_index !== el.index) begin
                        $error("element_index: expected %0d, got %0d", el.index,
                               o_element_index);
                        n_fail++;
                    end
                    if (o_last_element !== el.last) begin
                        $error("last_element: expected %0d, got %0d", el.last, o_last_element);
                        n_fail++;
                    end
                    if (o_error_flag !== el.err) begin
                        $error("error_flag: expected %0d, got %0d", el.err, o_error_flag);
                        n_fail++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_stall <= 1'b1;
            end else if (idling_on() && $urandom_range(0, 99) < 15) begin
                sink_gap = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        queue_quat(qnm_pkg::MODE_NORM, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_NORM, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd0, 16'sd0, 16'sd0, -16'sd1);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
        queue_quat(qnm_pkg::MODE_NORM, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd32767, -16'sd32768, 16'sd1, 16'sd0);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        queue_quat(qnm_pkg::MODE_NORM, 16'sd3, 16'sd5, -16'sd7, 16'sd11);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_MAT, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        queue_quat(qnm_pkg::MODE_MAT, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
        queue_quat(qnm_pkg::MODE_MAT, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        repeat (190) begin
            queue_quat(logic'($urandom_range(0, 1)), random_comp(), random_comp(),
                       random_comp(), random_comp());
        end
        n_items_total = quat_backlog.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (quat_backlog.size() != 0 || i_valid || expected_elems.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_fail == 0 && expected_elems.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
